FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked assertion forms used by the checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rssalu assertion failed");

// clocked assertion that also holds through reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rssalu assertion failed");

`endif

FILE: design/rssalu_pkg.sv
// ---------------------------------------------------------------------------
// rssalu_pkg
// shared types and constants of the replicated share ring alu
// ---------------------------------------------------------------------------
package rssalu_pkg;

  localparam int DATA_WIDTH_DEF = 64;

  localparam int FUNC_W = 3;
  localparam int FIELDS_IN = 9;  // data words per input word after func

  localparam int BIT_SIZE_W = 7;
  localparam logic [BIT_SIZE_W-1:0] BIT_SIZE_RESET = 7'd64;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_BIT_SIZE = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_SUB    = 3'd1,
    FUNC_MULT   = 3'd2,
    FUNC_SELECT = 3'd3,
    FUNC_DOT    = 3'd4,
    FUNC_OPEN   = 3'd5
  } func_t;

endpackage

FILE: design/replicated_share_ring_alu_unit.sv
// ---------------------------------------------------------------------------
// replicated_share_ring_alu_unit: three-party replicated share ring alu
// input, operand, partial product, cross sum and result registers; one input word
// per cycle while m_tready holds, set by half-width products and the add loop
// reset (synchronous): all stages empty, accumulator zero, bit_size 64
// ---------------------------------------------------------------------------
module replicated_share_ring_alu_unit #(
  parameter int DATA_WIDTH = rssalu_pkg::DATA_WIDTH_DEF,
  localparam int IN_BITS = rssalu_pkg::FUNC_W + rssalu_pkg::FIELDS_IN * DATA_WIDTH,
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8,
  localparam int M_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // input word stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // func, x_first, x_second, y_first, y_second, cond_first, cond_second,
  // mask_own, mask_next, peer_share (low bits up), zero padded
  input  logic [S_TDATA_W-1:0]                s_tdata,
  input  logic                                s_tlast,   // last
  // result word stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // z_first, z_second (low bits up), zero padded
  output logic [M_TDATA_W-1:0]                m_tdata,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rssalu_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rssalu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rssalu_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int LO_W   = (DATA_WIDTH + 1) / 2;
  localparam int HI_W   = DATA_WIDTH - LO_W;
  localparam int X0_LSB = rssalu_pkg::FUNC_W;
  localparam int X1_LSB = X0_LSB + DATA_WIDTH;
  localparam int Y0_LSB = X1_LSB + DATA_WIDTH;
  localparam int Y1_LSB = Y0_LSB + DATA_WIDTH;
  localparam int C0_LSB = Y1_LSB + DATA_WIDTH;
  localparam int C1_LSB = C0_LSB + DATA_WIDTH;
  localparam int R0_LSB = C1_LSB + DATA_WIDTH;
  localparam int R1_LSB = R0_LSB + DATA_WIDTH;
  localparam int PS_LSB = R1_LSB + DATA_WIDTH;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // ------------------------------------------------------------------------
  // configuration register
  // ------------------------------------------------------------------------
  logic [rssalu_pkg::BIT_SIZE_W-1:0] bit_size;
  logic                              cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2:2] == rssalu_pkg::REG_BIT_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_size <= rssalu_pkg::BIT_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      bit_size <= pwdata[rssalu_pkg::BIT_SIZE_W-1:0];
    end
  end

  assign prdata = cfg_hit ? rssalu_pkg::APB_DATA_W'(bit_size) : '0;

  // ring mask: bit i kept when i is below bit_size, widths above the word
  // give all ones and a zero width gives the one-element ring
  word_t ring_mask;

  always_comb begin
    for (int i = 0; i < DATA_WIDTH; i++) begin
      ring_mask[i] = (bit_size > rssalu_pkg::BIT_SIZE_W'(i));
    end
  end

  // ------------------------------------------------------------------------
  // stage handshake: each stage loads when empty or when it moves on,
  // so bubbles collapse and input keeps flowing behind a stalled result
  // ------------------------------------------------------------------------
  logic in_valid, op_valid, pp_valid, cs_valid;
  logic in_adv, op_adv, pp_adv, cs_adv, out_adv;

  assign out_adv  = !m_tvalid || m_tready;
  assign cs_adv   = !cs_valid || out_adv;
  assign pp_adv   = !pp_valid || cs_adv;
  assign op_adv   = !op_valid || pp_adv;
  assign in_adv   = !in_valid || op_adv;
  assign s_tready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      op_valid <= 1'b0;
      pp_valid <= 1'b0;
      cs_valid <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid <= s_tvalid;
      end
      if (op_adv) begin
        op_valid <= in_valid;
      end
      if (pp_adv) begin
        pp_valid <= op_valid;
      end
      if (cs_adv) begin
        cs_valid <= pp_valid;
      end
    end
  end

  // ------------------------------------------------------------------------
  // input register
  // ------------------------------------------------------------------------
  rssalu_pkg::func_t in_func;
  word_t in_x0, in_x1, in_y0, in_y1, in_c0, in_c1, in_r0, in_r1, in_peer;
  logic  in_last;

  always_ff @(posedge clk) begin
    if (in_adv) begin
      in_func <= rssalu_pkg::func_t'(s_tdata[rssalu_pkg::FUNC_W-1:0]);
      in_x0   <= s_tdata[X0_LSB +: DATA_WIDTH];
      in_x1   <= s_tdata[X1_LSB +: DATA_WIDTH];
      in_y0   <= s_tdata[Y0_LSB +: DATA_WIDTH];
      in_y1   <= s_tdata[Y1_LSB +: DATA_WIDTH];
      in_c0   <= s_tdata[C0_LSB +: DATA_WIDTH];
      in_c1   <= s_tdata[C1_LSB +: DATA_WIDTH];
      in_r0   <= s_tdata[R0_LSB +: DATA_WIDTH];
      in_r1   <= s_tdata[R1_LSB +: DATA_WIDTH];
      in_peer <= s_tdata[PS_LSB +: DATA_WIDTH];
      in_last <= s_tlast;
    end
  end

  // ------------------------------------------------------------------------
  // operand stage: select takes d = y - x against c, the rest take x
  // against y; cross sum is rewritten as a0*(b0+b1) + a1*b0
  // ------------------------------------------------------------------------
  logic  is_select;
  word_t a0_next, a1_next, b0_next, bsum_next, off_next, lin0_next, lin1_next;

  assign is_select = (in_func == rssalu_pkg::FUNC_SELECT);
  assign a0_next   = is_select ? in_y0 - in_x0 : in_x0;
  assign a1_next   = is_select ? in_y1 - in_x1 : in_x1;
  assign b0_next   = is_select ? in_c0 : in_y0;
  assign bsum_next = is_select ? in_c0 + in_c1 : in_y0 + in_y1;
  assign off_next  = in_r0 - in_r1;

  // share words that need no product
  always_comb begin
    case (in_func)
      rssalu_pkg::FUNC_ADD: begin
        lin0_next = in_x0 + in_y0;
        lin1_next = in_x1 + in_y1;
      end
      rssalu_pkg::FUNC_SUB: begin
        lin0_next = in_x0 - in_y0;
        lin1_next = in_x1 - in_y1;
      end
      rssalu_pkg::FUNC_OPEN: begin
        lin0_next = in_x0 + in_x1 + in_peer;
        lin1_next = '0;
      end
      default: begin
        lin0_next = '0;
        lin1_next = '0;
      end
    endcase
  end

  rssalu_pkg::func_t op_func;
  word_t op_a0, op_a1, op_b0, op_bsum, op_off, op_lin0, op_lin1;
  logic  op_last;

  always_ff @(posedge clk) begin
    if (op_adv) begin
      op_func <= in_func;
      op_a0   <= a0_next;
      op_a1   <= a1_next;
      op_b0   <= b0_next;
      op_bsum <= bsum_next;
      op_off  <= off_next;
      op_lin0 <= lin0_next;
      op_lin1 <= lin1_next;
      op_last <= in_last;
    end
  end

  // ------------------------------------------------------------------------
  // partial product stage
  // ------------------------------------------------------------------------
  logic [2*LO_W-1:0] ll0_next, ll1_next;
  logic [HI_W-1:0]   mid0_next, mid1_next;

  rssalu_pp_mult #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul0 (
    .a   (op_a0),
    .b   (op_bsum),
    .ll  (ll0_next),
    .mid (mid0_next)
  );

  rssalu_pp_mult #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul1 (
    .a   (op_a1),
    .b   (op_b0),
    .ll  (ll1_next),
    .mid (mid1_next)
  );

  rssalu_pkg::func_t pp_func;
  logic [2*LO_W-1:0] pp_ll0, pp_ll1;
  logic [HI_W-1:0]   pp_mid0, pp_mid1;
  word_t             pp_off, pp_lin0, pp_lin1;
  logic              pp_last;

  always_ff @(posedge clk) begin
    if (pp_adv) begin
      pp_func <= op_func;
      pp_ll0  <= ll0_next;
      pp_ll1  <= ll1_next;
      pp_mid0 <= mid0_next;
      pp_mid1 <= mid1_next;
      pp_off  <= op_off;
      pp_lin0 <= op_lin0;
      pp_lin1 <= op_lin1;
      pp_last <= op_last;
    end
  end

  // ------------------------------------------------------------------------
  // cross sum stage: both products folded into one word
  // ------------------------------------------------------------------------
  logic [HI_W-1:0] mid_sum;
  word_t           cross_next;

  assign mid_sum    = pp_mid0 + pp_mid1;
  assign cross_next = DATA_WIDTH'(pp_ll0) + DATA_WIDTH'(pp_ll1)
                    + {mid_sum, {LO_W{1'b0}}};

  rssalu_pkg::func_t cs_func;
  word_t cs_cross, cs_off, cs_lin0, cs_lin1;
  logic  cs_last;

  always_ff @(posedge clk) begin
    if (cs_adv) begin
      cs_func  <= pp_func;
      cs_cross <= cross_next;
      cs_off   <= pp_off;
      cs_lin0  <= pp_lin0;
      cs_lin1  <= pp_lin1;
      cs_last  <= pp_last;
    end
  end

  // ------------------------------------------------------------------------
  // result stage with the inner product accumulator
  // ------------------------------------------------------------------------
  word_t dot_acc;
  word_t acc_sum, prod_base, prod_z;
  word_t z0_raw, z1_raw;
  logic  emit;
  logic  cs_fire;

  assign cs_fire   = cs_valid && out_adv;
  assign acc_sum   = dot_acc + cs_cross;
  // inner product folds the running sum into the outgoing share
  assign prod_base = (cs_func == rssalu_pkg::FUNC_DOT) ? dot_acc : '0;
  assign prod_z    = prod_base + cs_cross + cs_off;

  always_comb begin
    case (cs_func)
      rssalu_pkg::FUNC_ADD, rssalu_pkg::FUNC_SUB: begin
        z0_raw = cs_lin0;
        z1_raw = cs_lin1;
        emit   = 1'b1;
      end
      rssalu_pkg::FUNC_MULT, rssalu_pkg::FUNC_SELECT: begin
        z0_raw = prod_z;
        z1_raw = '0;
        emit   = 1'b1;
      end
      rssalu_pkg::FUNC_DOT: begin
        // only the element marked last hands out a word
        z0_raw = prod_z;
        z1_raw = '0;
        emit   = cs_last;
      end
      rssalu_pkg::FUNC_OPEN: begin
        z0_raw = cs_lin0;
        z1_raw = '0;
        emit   = 1'b1;
      end
      default: begin
        // unused codes: no word and no state change
        z0_raw = '0;
        z1_raw = '0;
        emit   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc <= '0;
    end else if (cs_fire && cs_func == rssalu_pkg::FUNC_DOT) begin
      dot_acc <= cs_last ? '0 : (acc_sum & ring_mask);
    end
  end

  word_t z_first, z_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= cs_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      z_first  <= z0_raw & ring_mask;
      z_second <= z1_raw & ring_mask;
    end
  end

  assign m_tdata = M_TDATA_W'({z_second, z_first});

endmodule

FILE: design/rssalu_pp_mult.sv
// ---------------------------------------------------------------------------
// rssalu_pp_mult
// low-word product split into half-width partial products
// ---------------------------------------------------------------------------
module rssalu_pp_mult #(
  parameter int DATA_WIDTH = rssalu_pkg::DATA_WIDTH_DEF,
  localparam int LO_W = (DATA_WIDTH + 1) / 2,
  localparam int HI_W = DATA_WIDTH - LO_W
) (
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic [2*LO_W-1:0]     ll,
  output logic [HI_W-1:0]       mid
);

  logic [LO_W-1:0]      a_lo;
  logic [LO_W-1:0]      b_lo;
  logic [HI_W-1:0]      a_hi;
  logic [HI_W-1:0]      b_hi;
  logic [LO_W+HI_W-1:0] lh_full;
  logic [LO_W+HI_W-1:0] hl_full;

  assign a_lo = a[LO_W-1:0];
  assign b_lo = b[LO_W-1:0];
  assign a_hi = a[DATA_WIDTH-1:LO_W];
  assign b_hi = b[DATA_WIDTH-1:LO_W];

  assign ll      = (2*LO_W)'(a_lo) * (2*LO_W)'(b_lo);
  assign lh_full = DATA_WIDTH'(a_lo) * DATA_WIDTH'(b_hi);
  assign hl_full = DATA_WIDTH'(a_hi) * DATA_WIDTH'(b_lo);

  // only the bits that land below the word top after the shift matter
  assign mid = lh_full[HI_W-1:0] + hl_full[HI_W-1:0];

endmodule

FILE: design/rssalu_checker.sv
// ---------------------------------------------------------------------------
// rssalu_checker
// port-level checks of the replicated share ring alu, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rssalu_checker #(
  parameter int DATA_WIDTH = rssalu_pkg::DATA_WIDTH_DEF,
  localparam int M_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [M_TDATA_W-1:0]              m_tdata,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [rssalu_pkg::APB_ADDR_W-1:0] paddr,
  input logic [rssalu_pkg::APB_DATA_W-1:0] pwdata,
  input logic [rssalu_pkg::APB_DATA_W-1:0] prdata,
  input logic                              pready
);

  logic cfg_write;

  assign cfg_write = psel && penable && pwrite && pready
                  && paddr[2:2] == rssalu_pkg::REG_BIT_SIZE;

  // the written width reads back with the upper bits clear
  property p_cfg_readback;
    cfg_write |=> paddr[2:2] != rssalu_pkg::REG_BIT_SIZE
      || (prdata[rssalu_pkg::BIT_SIZE_W-1:0] == $past(pwdata[rssalu_pkg::BIT_SIZE_W-1:0])
          && prdata[rssalu_pkg::APB_DATA_W-1:rssalu_pkg::BIT_SIZE_W] == '0);
  endproperty

  // reset leaves no result word behind
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // with the result register empty every stage can load, so input is open
  `ASSERT_CLK(a_empty_out_ready, clk, rst, !m_tvalid |-> s_tready)

  // a stalled result word holds
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // written ring width reads back
  `ASSERT_CLK(a_cfg_readback, clk, rst, p_cfg_readback)

endmodule

bind replicated_share_ring_alu_unit rssalu_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rssalu_checker (.*);
